@@ hw/rtl/lzbq_pkg.sv @@
`default_nettype none
package lzbq_pkg;
  localparam int unsigned WindowSize  = 8192;
  localparam int unsigned HeaderBytes = 6;
  localparam int unsigned OutLanes    = 8;
  localparam logic [7:0]  HdrSum      = 8'hAB;

  typedef enum logic [2:0] {
    ST_RUN     = 3'd0,
    ST_OK      = 3'd1,
    ST_HDR     = 3'd2,
    ST_TRUNC   = 3'd3,
    ST_BACKREF = 3'd4
  } status_e;

  // parser phases of the token grammar
  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_TYPE   = 4'd1,
    PH_METHOD = 4'd2,
    PH_LEN1   = 4'd3,
    PH_LEN2   = 4'd4,
    PH_HTYPE  = 4'd5,
    PH_HMETH  = 4'd6,
    PH_HLEN1  = 4'd7,
    PH_HLEN2  = 4'd8,
    PH_LIT    = 4'd9,
    PH_SOFS   = 4'd10,
    PH_WLO    = 4'd11,
    PH_WHI    = 4'd12,
    PH_LENB   = 4'd13
  } phase_e;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_BITS  = 6'b000010,
    S_RD    = 6'b000100,
    S_WR    = 6'b001000,
    S_FLUSH = 6'b010000,
    S_DONE  = 6'b100000
  } fsm_e;
endpackage
`default_nettype wire

@@ hw/rtl/lzbq_stream_if.sv @@
`default_nettype none
interface lzbq_stream_if #(
  parameter int unsigned Width = 8
) ();
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lzbq_history_ram.sv @@
`default_nettype none
module lzbq_history_ram #(
  parameter int unsigned Depth = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [7:0]               wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [7:0]               rdata_o
);
  logic [7:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ hw/rtl/lz_bitqueue_decompressor_unit.sv @@
`default_nettype none
// LZ decompressor with a 16-bit inline control-bit queue.
// in_req (sink): one compressed byte per request, {in_last, in_byte}.
// out_req (source): {run_end, status, out_count, out_bytes}; up to
// OutLanes bytes per result, earliest byte in the lowest lane.
// Every input request yields one or more results; the last one carries
// run_end and the status (0 run, 1 ok, 2 header, 3 truncated, 4 backref).
// From request accept to the next ready, a header or token byte is decoded,
// then queued control bits are stepped one at a time (a queue refill steps
// up to 3 bits, a finished token up to 4), then the result is sent. A
// literal is written to history before its bit steps. A back-reference
// walks the history RAM one byte at a time (registered read, then write),
// waiting while a full pack cannot be handed on; one item is in flight at a
// time and in_ready is low while it is worked on.
// The output register holds its result while the receiver stalls; the
// decoder simply waits. Reset clears all control state; the history RAM
// is not cleared, only entries already written are ever read.
// After in_last all stream state returns to reset.
module lz_bitqueue_decompressor_unit
  import lzbq_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = WindowSize,
  parameter int unsigned OUT_LANES   = OutLanes
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lzbq_stream_if.sink   in_req,
  lzbq_stream_if.source out_req
);
  localparam int unsigned AW = $clog2(WINDOW_SIZE);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned LW = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;

  fsm_e             state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [AW-1:0]    wpos_q, wpos_d;
  logic [PW-1:0]    prod_q, prod_d;
  logic [15:0]      bq_q, bq_d;
  logic [7:0]       hsum_q, hsum_d;
  logic [2:0]       hidx_q, hidx_d;
  logic [7:0]       held_q, held_d;
  logic [8:0]       tlen_q, tlen_d;
  logic [PW-1:0]    tofs_q, tofs_d;
  logic             over_q, over_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic [2:0]       st_q, st_d;
  logic [8:0]       cnt_q, cnt_d;     // copy bytes left
  logic [63:0]      pack_q, pack_d;
  logic [3:0]       npk_q, npk_d;
  logic             ov_q, ov_d;
  logic [63:0]      ob_q, ob_d;
  logic [3:0]       oc_q, oc_d;
  logic             oe_q, oe_d;
  logic [2:0]       os_q, os_d;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [7:0]       wdata, rdata;

  lzbq_history_ram #(.Depth(WINDOW_SIZE)) u_hist (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign in_req.ready  = (state_q == S_IDLE);
  assign out_req.valid = ov_q;
  assign out_req.data  = {oe_q, os_q, oc_q, ob_q};

  logic        out_free;
  logic [15:0] word;
  logic [PW-1:0] bk_dist;
  assign out_free = !ov_q || out_req.ready;
  assign word  = {byte_q, held_q};
  assign raddr = AW'(wpos_q - AW'(tofs_q));

  always_comb begin
    state_d = state_q; phase_d = phase_q; wpos_d = wpos_q; prod_d = prod_q;
    bq_d = bq_q; hsum_d = hsum_q; hidx_d = hidx_q; held_d = held_q;
    tlen_d = tlen_q; tofs_d = tofs_q; over_d = over_q; byte_d = byte_q;
    last_d = last_q; st_d = st_q; cnt_d = cnt_q; pack_d = pack_q;
    npk_d = npk_q; ov_d = ov_q && !out_req.ready; ob_d = ob_q; oc_d = oc_q;
    oe_d = oe_q; os_d = os_q;
    we = 1'b0; waddr = wpos_q; wdata = byte_q; bk_dist = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_req.valid) begin
          byte_d = in_req.data[7:0];
          last_d = in_req.data[8];
          st_d = ST_RUN; npk_d = '0; pack_d = '0; cnt_d = '0;
          state_d = over_q ? S_DONE : S_BITS;
        end
      end
      S_BITS: begin
        // one byte of the token grammar; a copy sets cnt and tofs
        state_d = S_DONE;
        unique case (phase_q)
          PH_HEADER: begin
            hsum_d = hsum_q + byte_q;
            hidx_d = hidx_q + 3'd1;
            if (hidx_q == 3'(HeaderBytes - 1)) begin
              if (hsum_d != HdrSum) st_d = ST_HDR;
              else begin bq_d = '0; phase_d = PH_TYPE; state_d = S_FLUSH; end
            end
          end
          PH_TYPE, PH_METHOD, PH_LEN1, PH_LEN2: begin
            held_d = byte_q;
            phase_d = phase_e'(phase_q + 4'd4);
          end
          PH_HTYPE, PH_HMETH, PH_HLEN1, PH_HLEN2: begin
            bq_d = {1'b1, word[15:1]};
            unique case (phase_q)
              PH_HTYPE:  phase_d = word[0] ? PH_LIT : PH_METHOD;
              PH_HMETH: begin tlen_d = '0; phase_d = word[0] ? PH_WLO : PH_LEN1; end
              PH_HLEN1: begin tlen_d = {8'd0, word[0]}; phase_d = PH_LEN2; end
              default: begin tlen_d = {7'd0, tlen_q[0], word[0]}; phase_d = PH_SOFS; end
            endcase
            state_d = S_FLUSH;
          end
          PH_LIT: begin
            cnt_d = 9'd1; tofs_d = '0; phase_d = PH_TYPE; state_d = S_WR;
          end
          PH_SOFS: begin
            bk_dist = PW'(9'd256 - {1'b0, byte_q});
            tofs_d = bk_dist; phase_d = PH_TYPE;
            if (bk_dist > prod_q) st_d = ST_BACKREF;
            else begin cnt_d = tlen_q + 9'd2; state_d = S_RD; end
          end
          PH_WLO: begin held_d = byte_q; phase_d = PH_WHI; state_d = S_FLUSH; end
          PH_WHI: begin
            bk_dist = PW'(14'd8192 - {1'b0, word[15:3]});
            tofs_d = bk_dist;
            if (word[2:0] == 3'd0) begin phase_d = PH_LENB; state_d = S_FLUSH; end
            else begin
              phase_d = PH_TYPE;
              if (bk_dist > prod_q) st_d = ST_BACKREF;
              else begin cnt_d = {6'd0, word[2:0]} + 9'd2; state_d = S_RD; end
            end
          end
          PH_LENB: begin
            phase_d = PH_TYPE;
            if (byte_q == 8'd0) st_d = ST_OK;
            else if (tofs_q > prod_q) st_d = ST_BACKREF;
            else begin cnt_d = {1'b0, byte_q} + 9'd2; state_d = S_RD; end
          end
          default: st_d = ST_TRUNC;
        endcase
      end
      S_RD: state_d = S_WR;      // history read in flight
      S_WR: begin
        // one byte into history and the pack register
        if (npk_q != 4'(OUT_LANES) || out_free) begin
          wdata = (tofs_q == '0) ? byte_q : rdata;
          we = 1'b1;
          wpos_d = wpos_q + AW'(1);
          if (prod_q != PW'(WINDOW_SIZE)) prod_d = prod_q + PW'(1);
          cnt_d = cnt_q - 9'd1;
          if (npk_q == 4'(OUT_LANES)) begin
            ov_d = 1'b1; ob_d = pack_q; oc_d = npk_q; oe_d = 1'b0; os_d = ST_RUN;
            pack_d = {56'd0, wdata}; npk_d = 4'd1;
          end else begin
            pack_d = pack_q | ({56'd0, wdata} << {npk_q[LW-1:0], 3'b000});
            npk_d = npk_q + 4'd1;
          end
          state_d = (cnt_q == 9'd1) ? S_FLUSH : S_RD;
        end
      end
      S_FLUSH: begin
        // step the control queue one bit a cycle while bits are left
        if ((phase_q == PH_TYPE || phase_q == PH_METHOD || phase_q == PH_LEN1 ||
             phase_q == PH_LEN2) && bq_q > 16'd1) begin
          bq_d = {1'b0, bq_q[15:1]};
          unique case (phase_q)
            PH_TYPE:   phase_d = bq_q[0] ? PH_LIT : PH_METHOD;
            PH_METHOD: begin tlen_d = '0; phase_d = bq_q[0] ? PH_WLO : PH_LEN1; end
            PH_LEN1:   begin tlen_d = {8'd0, bq_q[0]}; phase_d = PH_LEN2; end
            default:   begin tlen_d = {7'd0, tlen_q[0], bq_q[0]}; phase_d = PH_SOFS; end
          endcase
        end else state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          logic [2:0] fst;
          fst = st_q;
          if (!over_q && fst == ST_RUN && last_q)
            fst = (phase_q == PH_HEADER) ? ST_HDR :
                  (phase_q == PH_LIT) ? ST_OK : ST_TRUNC;
          if (!over_q && fst != ST_RUN) over_d = 1'b1;
          ov_d = 1'b1; ob_d = pack_q; oc_d = npk_q; oe_d = 1'b1; os_d = fst;
          state_d = S_IDLE;
          if (last_q) begin
            wpos_d = '0; prod_d = '0; bq_d = '0; phase_d = PH_HEADER; hsum_d = '0;
            hidx_d = '0; held_d = '0; tlen_d = '0; tofs_d = '0; over_d = 1'b0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; phase_q <= PH_HEADER; wpos_q <= '0; prod_q <= '0;
      bq_q <= '0; hsum_q <= '0; hidx_q <= '0; held_q <= '0; tlen_q <= '0;
      tofs_q <= '0; over_q <= 1'b0; ov_q <= 1'b0; st_q <= ST_RUN;
      cnt_q <= '0; npk_q <= '0; last_q <= 1'b0;
    end else begin
      state_q <= state_d; phase_q <= phase_d; wpos_q <= wpos_d; prod_q <= prod_d;
      bq_q <= bq_d; hsum_q <= hsum_d; hidx_q <= hidx_d; held_q <= held_d;
      tlen_q <= tlen_d; tofs_q <= tofs_d; over_q <= over_d; ov_q <= ov_d;
      st_q <= st_d; cnt_q <= cnt_d; npk_q <= npk_d; last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d; pack_q <= pack_d; ob_q <= ob_d; oc_q <= oc_d;
    oe_q <= oe_d; os_q <= os_d;
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req.ready |-> state_q == S_IDLE) else $error("ready outside idle");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> oc_q <= 4'(OUT_LANES)) else $error("count too large");
  a_status_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !oe_q) |-> os_q == ST_RUN) else $error("status before end");
  a_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_q <= PW'(WINDOW_SIZE)) else $error("produced overflow");
endmodule
`default_nettype wire

@@ tb/sv/tb_lz_bitqueue_decompressor_unit.sv @@
module tb_lz_bitqueue_decompressor_unit;
  import lzbq_pkg::*;

  // Compressed byte plus end-of-stream flag; hold_until_drained makes the
  // sender wait until all earlier results are back before offering it.
  typedef struct {
    logic [7:0] in_byte;
    logic       in_last;
    bit         hold_until_drained;
  } comp_byte_t;

  typedef struct {
    logic [63:0] out_bytes;
    logic [3:0]  out_count;
    logic        run_end;
    status_e     status;
  } chunk_t;

  localparam int unsigned RunMax = 257;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lzbq_stream_if #(.Width(9))  in_if ();
  lzbq_stream_if #(.Width(72)) out_if ();

  lz_bitqueue_decompressor_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_req (in_if),
    .out_req(out_if)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Decoder shadow: mirrors the stream state of the block. It runs while
  // the stimulus is built, so it also steers the generator toward legal
  // back-reference distances.
  // ---------------------------------------------------------------------
  logic [7:0]  win_mem [WindowSize];
  int unsigned win_wr_pos;
  int unsigned win_fill;
  int unsigned ctl_bits;
  phase_e      dec_phase;
  int unsigned hdr_sum;
  int unsigned hdr_idx;
  int unsigned held_lo;
  int unsigned tok_len;
  int unsigned tok_dist;
  bit          stream_dead;
  logic [7:0]  copy_run [$];

  comp_byte_t  comp_q [$];       // bytes waiting to be offered
  int unsigned chunks_per_byte_q [$];
  chunk_t      chunk_q [$];      // expected results, oldest first

  int unsigned chunks_issued = 0;  // results owed by accepted requests
  int unsigned chunks_seen   = 0;
  int unsigned bytes_taken   = 0;
  int unsigned n_errors      = 0;

  function automatic void clear_stream();
    win_wr_pos  = 0;
    win_fill    = 0;
    ctl_bits    = 0;
    dec_phase   = PH_HEADER;
    hdr_sum     = 0;
    hdr_idx     = 0;
    held_lo     = 0;
    tok_len     = 0;
    tok_dist    = 0;
    stream_dead = 1'b0;
  endfunction

  function automatic void put_out(logic [7:0] b);
    win_mem[win_wr_pos] = b;
    win_wr_pos = (win_wr_pos + 1) % WindowSize;
    if (win_fill < WindowSize) win_fill++;
    if (copy_run.size() < RunMax) copy_run = {copy_run, b};
  endfunction

  function automatic status_e copy_back(int unsigned len, int unsigned back_dist);
    if (back_dist > win_fill) return ST_BACKREF;
    for (int unsigned n = 0; n < len; n++)
      put_out(win_mem[(win_wr_pos + WindowSize - back_dist) % WindowSize]);
    return ST_RUN;
  endfunction

  function automatic void apply_bit(phase_e p, bit b);
    case (p)
      PH_TYPE: dec_phase = b ? PH_LIT : PH_METHOD;
      PH_METHOD: begin
        tok_len   = 0;
        dec_phase = b ? PH_WLO : PH_LEN1;
      end
      PH_LEN1: begin
        tok_len   = b;
        dec_phase = PH_LEN2;
      end
      default: begin
        tok_len   = ((tok_len << 1) | b) & 3;
        dec_phase = PH_SOFS;
      end
    endcase
  endfunction

  // Consume queued control bits until a byte is needed (bit 15 is the
  // sentinel, so a queue value of 1 means empty).
  function automatic void drain_bits();
    bit b;
    while (dec_phase >= PH_TYPE && dec_phase <= PH_LEN2 && ctl_bits > 1) begin
      b = ctl_bits[0];
      ctl_bits = ctl_bits >> 1;
      apply_bit(dec_phase, b);
    end
  endfunction

  function automatic status_e eat_byte(int unsigned b);
    status_e     st;
    int unsigned w;
    phase_e      p;
    st = ST_RUN;
    p  = dec_phase;
    if (p == PH_HEADER) begin
      hdr_sum = (hdr_sum + b) & 8'hFF;
      hdr_idx++;
      if (hdr_idx >= HeaderBytes) begin
        if (hdr_sum != HdrSum) return ST_HDR;
        ctl_bits  = 0;
        dec_phase = PH_TYPE;
      end
    end else if (p >= PH_TYPE && p <= PH_LEN2) begin
      held_lo   = b;
      dec_phase = phase_e'(p + 4);
    end else if (p >= PH_HTYPE && p <= PH_HLEN2) begin
      w = held_lo | (b << 8);
      ctl_bits = (w >> 1) | 16'h8000;
      apply_bit(phase_e'(p - 4), w[0]);
    end else if (p == PH_LIT) begin
      put_out(b[7:0]);
      dec_phase = PH_TYPE;
    end else if (p == PH_SOFS) begin
      st = copy_back(tok_len + 2, 256 - b);
      dec_phase = PH_TYPE;
    end else if (p == PH_WLO) begin
      held_lo   = b;
      dec_phase = PH_WHI;
    end else if (p == PH_WHI) begin
      w = held_lo | (b << 8);
      tok_dist = 8192 - (w >> 3);
      if ((w & 7) == 0) begin
        dec_phase = PH_LENB;
      end else begin
        st = copy_back((w & 7) + 2, tok_dist);
        dec_phase = PH_TYPE;
      end
    end else begin
      if (b == 0) return ST_OK;   // zero length byte terminates
      st = copy_back(b + 2, tok_dist);
      dec_phase = PH_TYPE;
    end
    if (st == ST_RUN) drain_bits();
    return st;
  endfunction

  // Runs one compressed byte through the shadow and queues its results.
  function automatic void add_byte(logic [7:0] b, logic last, bit hold);
    status_e     st;
    int unsigned nres;
    chunk_t      c;
    comp_byte_t  it;
    st = ST_RUN;
    copy_run.delete();
    if (!stream_dead) begin
      st = eat_byte(b);
      if (st == ST_RUN && last) begin
        if (dec_phase == PH_HEADER)   st = ST_HDR;
        else if (dec_phase == PH_LIT) st = ST_OK;
        else                          st = ST_TRUNC;
      end
      if (st != ST_RUN) stream_dead = 1'b1;
    end
    if (last) clear_stream();
    nres = (copy_run.size() + OutLanes - 1) / OutLanes;
    if (nres == 0) nres = 1;
    for (int unsigned r = 0; r < nres; r++) begin
      c.out_bytes = '0;
      c.out_count = '0;
      for (int unsigned k = 0; k < OutLanes; k++) begin
        if (r * OutLanes + k < copy_run.size()) begin
          c.out_bytes[8*k +: 8] = copy_run[r * OutLanes + k];
          c.out_count++;
        end
      end
      c.run_end = (r + 1 == nres);
      c.status  = (r + 1 == nres) ? st : ST_RUN;
      chunk_q = {chunk_q, c};
    end
    it.in_byte = b;
    it.in_last = last;
    it.hold_until_drained = hold;
    comp_q = {comp_q, it};
    chunks_per_byte_q = {chunks_per_byte_q, nres};
  endfunction

  // Picks the next byte of a mostly well-formed stream from the decoder
  // state: good header sums, distances inside the window, short lengths.
  int unsigned pending_word;
  function automatic logic [7:0] pick_byte();
    int unsigned back_dist;
    int unsigned lim;
    case (dec_phase)
      PH_HEADER:
        if (hdr_idx == HeaderBytes - 1 && $urandom_range(9) != 0)
          return 8'(HdrSum - hdr_sum);
        else
          return 8'($urandom);
      PH_SOFS: begin
        if (win_fill == 0 || $urandom_range(19) == 0) return 8'($urandom);
        lim  = win_fill < 256 ? win_fill : 256;
        back_dist = $urandom_range(lim, 1);
        return 8'(256 - back_dist);
      end
      PH_WLO: begin
        if (win_fill == 0 || $urandom_range(19) == 0) begin
          pending_word = $urandom_range(16'hFFFF);
        end else begin
          lim  = win_fill < 8192 ? win_fill : 8192;
          back_dist = ($urandom_range(3) == 0) ? $urandom_range(lim, 1)
                                               : $urandom_range(lim < 16 ? lim : 16, 1);
          pending_word = ((8192 - back_dist) % 8192) << 3;
          pending_word |= ($urandom_range(3) == 0) ? 0 : $urandom_range(7, 1);
        end
        return pending_word[7:0];
      end
      PH_WHI: return pending_word[15:8];
      PH_LENB: begin
        if ($urandom_range(11) == 0) return 8'h00;
        if ($urandom_range(9) == 0) return 8'($urandom_range(255, 1));
        return 8'($urandom_range(20, 1));
      end
      default: return 8'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Idle mix by progress: sender 29% / receiver 75%, then swapped, then
  // both at full rate.
  // ---------------------------------------------------------------------
  int unsigned n_planned;
  function automatic int unsigned send_idle_pct();
    if (bytes_taken < n_planned / 3)     return 29;
    if (bytes_taken < 2 * n_planned / 3) return 75;
    return 0;
  endfunction
  function automatic int unsigned recv_idle_pct();
    if (bytes_taken < n_planned / 3)     return 75;
    if (bytes_taken < 2 * n_planned / 3) return 29;
    return 0;
  endfunction

  // ---------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------
  int unsigned cur_nres;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
      cur_nres    = 0;
    end else if (!(in_if.valid && !in_if.ready)) begin
      if (in_if.valid && in_if.ready) begin
        chunks_issued += cur_nres;
        bytes_taken++;
      end
      if (comp_q.size() != 0 && $urandom_range(99) >= send_idle_pct() &&
          !(comp_q[0].hold_until_drained && chunks_issued != chunks_seen)) begin
        in_if.valid <= 1'b1;
        in_if.data  <= {comp_q[0].in_last, comp_q[0].in_byte};
        cur_nres = chunks_per_byte_q.pop_front();
        void'(comp_q.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Long receiver stall: once, early on, ready is held low for a long
  // stretch so the block backs up.
  // ---------------------------------------------------------------------
  int unsigned stall_left;
  bit          stall_done;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && bytes_taken >= 60) begin
      stall_done <= 1'b1;
      stall_left <= 1500;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks every result against the oldest expectation.
  // ---------------------------------------------------------------------
  chunk_t      want;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        chunks_seen++;
        if (chunk_q.size() == 0) begin
          $error("result with no expectation: %h", out_if.data);
          n_errors++;
        end else begin
          want = chunk_q.pop_front();
          if (out_if.data[63:0] !== want.out_bytes) begin
            $error("out_bytes exp %h got %h", want.out_bytes, out_if.data[63:0]);
            n_errors++;
          end
          if (out_if.data[67:64] !== want.out_count) begin
            $error("out_count exp %0d got %0d", want.out_count, out_if.data[67:64]);
            n_errors++;
          end
          if (out_if.data[70:68] !== want.status) begin
            $error("status exp %0d got %0d", want.status, out_if.data[70:68]);
            n_errors++;
          end
          if (out_if.data[71] !== want.run_end) begin
            $error("run_end exp %0d got %0d", want.run_end, out_if.data[71]);
            n_errors++;
          end
        end
      end
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct());
      end
    end
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    int unsigned target;
    int unsigned i;
    logic [7:0]  b;
    bit          last;
    bit          hold;
    logic [7:0]  hdr_ok [6];

    clear_stream();
    hdr_ok = '{8'hAB, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

    // Short header: in_last after three bytes.
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h55, 1'b1, 1'b0);
    // Bad header sum, then a dropped byte up to in_last.
    for (i = 0; i < 6; i++) add_byte(8'h01, 1'b0, 1'b0);
    add_byte(8'h77, 1'b1, 1'b0);
    // Literals only, ending on a literal wait: finished ok.
    foreach (hdr_ok[k]) add_byte(hdr_ok[k], 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h5A, 1'b1, 1'b0);
    // Short back-reference with nothing produced yet: bad backref.
    foreach (hdr_ok[k]) add_byte(hdr_ok[k], 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h80, 1'b1, 1'b0);
    // Truncated: stream ends waiting for the queue refill.
    foreach (hdr_ok[k]) add_byte(hdr_ok[k], 1'b0, 1'b0);
    add_byte(8'h3C, 1'b1, 1'b0);

    // Random streams: mostly well-formed with random token mix.
    n_planned = comp_q.size() + 400;
    hold = 1'b1;   // first random byte waits for the directed part to drain
    while (comp_q.size() < n_planned) begin
      target = ($urandom_range(7) == 0) ? $urandom_range(8, 1) : $urandom_range(80, 12);
      i = 0;
      do begin
        b = pick_byte();
        last = (i + 1 >= target) &&
               (dec_phase == PH_LIT || stream_dead || $urandom_range(3) == 0 ||
                i > target + 30);
        add_byte(b, last, hold);
        hold = (comp_q.size() == n_planned / 2);
        i++;
      end while (!last);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (comp_q.size() == 0);
    @(posedge clk);
    wait (!in_if.valid && chunks_issued == chunks_seen);
    repeat (600) @(posedge clk);

    if (n_errors == 0 && chunk_q.size() == 0) begin
      $display("status: pass");
    end else begin
      if (chunk_q.size() != 0) $error("%0d expected results never came", chunk_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
